// ===== src/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg: shared types, constants and functions of the crc8 packet framer
// item and result payload structs, controller/datapath link, crc8 byte step
// ----------------------------------------------------------------------------
package cpf_pkg;

  // default payload capacity in bytes
  localparam int MAX_PAYLOAD_DEF = 16;

  localparam logic [7:0] SYNC_A   = 8'hB4;
  localparam logic [7:0] SYNC_B   = 8'hE9;
  localparam logic [7:0] CRC_POLY = 8'hE7;

  // header byte positions
  localparam logic [1:0] STEP_SYNC_A = 2'd0;
  localparam logic [1:0] STEP_SYNC_B = 2'd1;
  localparam logic [1:0] STEP_LEN    = 2'd2;
  localparam logic [1:0] STEP_CRC    = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       too_long;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // take the accepted request into the store
    logic clear;     // frame done: drop count and overflow mark
    logic restart;   // zero crc, header step and read pointer
    logic crc_hdr;   // fold the current header byte into the crc
    logic crc_pay;   // fold the current payload byte into the crc
    logic step_inc;
    logic ptr_clr;
    logic ptr_inc;
    logic emit_hdr;
    logic emit_pay;
    logic emit_err;
    logic emit_end;
  } cpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ovf_next;    // overflow after the request at the input
    logic count_zero;
    logic step_last;
    logic ptr_last;
  } cpf_sts_t;

  // one byte of the crc: xor in, then shift and test bit 7 eight times
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = {c[6:0], 1'b0};
      if (c[7]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/cpf_ram.sv =====
// ----------------------------------------------------------------------------
// cpf_ram: generic single-port-write ram with registered read
// one write and one read address per cycle, read data valid next cycle
// ----------------------------------------------------------------------------
module cpf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cpf_datapath.sv =====
// ----------------------------------------------------------------------------
// cpf_datapath: payload store, byte count, crc register and result register
// acts on commands from the controller, reports count and pointer status
// ----------------------------------------------------------------------------
module cpf_datapath import cpf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cpf_cmd_t  cmd,
  output cpf_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          full;
  logic          wr_en;
  logic [7:0]    rd_data;
  logic [7:0]    hdr_byte;
  logic [CW-1:0] ptr_plus1;

  assign full      = (count_r == CW'(MAX_PAYLOAD));
  assign wr_en     = cmd.load & in_data.has_byte & ~full;
  assign ptr_plus1 = CW'(ptr_r) + CW'(1);

  // read address follows the next pointer, so rd_data holds store[ptr_r] unless that entry was just written
  cpf_ram #(
    .WIDTH  (8),
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_data.payload_byte),
    .rd_addr (ptr_nxt),
    .rd_data (rd_data)
  );

  // crc position reads as zero while the crc is being built
  always_comb begin
    case (step_r)
      STEP_SYNC_A: hdr_byte = SYNC_A;
      STEP_SYNC_B: hdr_byte = SYNC_B;
      STEP_LEN:    hdr_byte = 8'(count_r);
      STEP_CRC:    hdr_byte = cmd.emit_hdr ? crc_r : 8'h00;
      default:     hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.load && in_data.has_byte) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end

    crc_nxt = crc_r;
    if (cmd.restart) begin
      crc_nxt = 8'h00;
    end else if (cmd.crc_hdr) begin
      crc_nxt = crc_feed(crc_r, hdr_byte);
    end else if (cmd.crc_pay) begin
      crc_nxt = crc_feed(crc_r, rd_data);
    end

    step_nxt = step_r;
    if (cmd.restart) begin
      step_nxt = STEP_SYNC_A;
    end else if (cmd.step_inc) begin
      step_nxt = step_r + 2'd1;
    end

    ptr_nxt = ptr_r;
    if (cmd.restart || cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + AW'(1);
    end

    out_valid_nxt = cmd.emit_hdr | cmd.emit_pay | cmd.emit_err;
    out_nxt.frame_byte = cmd.emit_hdr ? hdr_byte : (cmd.emit_pay ? rd_data : 8'h00);
    out_nxt.frame_end  = cmd.emit_end | cmd.emit_err;
    out_nxt.too_long   = cmd.emit_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      step_r      <= STEP_SYNC_A;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      step_r      <= step_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    crc_r <= crc_nxt;
    out_r <= out_nxt;
  end

  assign sts.ovf_next   = ovf_r | (in_data.has_byte & full);
  assign sts.count_zero = (count_r == '0);
  assign sts.step_last  = (step_r == STEP_CRC);
  assign sts.ptr_last   = (ptr_plus1 == count_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/cpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpf_ctrl: frame sequencer
// collects requests, walks the crc over header and payload, then emits
// ----------------------------------------------------------------------------
module cpf_ctrl import cpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     is_last,
  input  cpf_sts_t sts,
  output logic     busy,
  output cpf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_CRC,
    S_PAY_CRC,
    S_EMIT_HDR,
    S_EMIT_PAY,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.restart = 1'b1;
        if (start) begin
          cmd.load = 1'b1;
          if (is_last) begin
            state_nxt = sts.ovf_next ? S_ERR : S_HDR_CRC;
          end
        end
      end
      S_HDR_CRC: begin
        cmd.crc_hdr  = 1'b1;
        cmd.step_inc = 1'b1;
        if (sts.step_last) begin
          state_nxt = sts.count_zero ? S_EMIT_HDR : S_PAY_CRC;
        end
      end
      S_PAY_CRC: begin
        cmd.crc_pay = 1'b1;
        if (sts.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = S_EMIT_HDR;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_EMIT_HDR: begin
        cmd.emit_hdr = 1'b1;
        cmd.step_inc = 1'b1;
        if (sts.step_last) begin
          if (sts.count_zero) begin
            cmd.emit_end = 1'b1;
            cmd.clear    = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_EMIT_PAY;
          end
        end
      end
      S_EMIT_PAY: begin
        cmd.emit_pay = 1'b1;
        if (sts.ptr_last) begin
          cmd.emit_end = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_ERR: begin
        cmd.emit_err = 1'b1;
        cmd.clear    = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== src/crc8_packet_framer.sv =====
// ----------------------------------------------------------------------------
// crc8_packet_framer: builds crc8-protected frames from payload bytes
// header 0xB4 0xE9 length crc, then the buffered payload bytes
// ----------------------------------------------------------------------------
// usage
//   input: a request is taken at a rising edge with start high and busy low;
//   in_data carries one optional payload byte (has_byte) and a last mark
//   (is_last). requests without the last mark are taken one per cycle and
//   only fill the payload store.
//   a request with the last mark raises busy; the block then runs the crc
//   one byte per cycle over the four header bytes (crc position as zero)
//   and the n stored bytes, then emits the n+4 frame bytes one per cycle.
//   the first frame byte strobes once the crc has covered all n+4 bytes,
//   and busy falls as the last frame byte strobes.
//   if more than MAX_PAYLOAD bytes arrived, extra bytes are dropped and the
//   closing request gives a single flagged result (byte 0, frame_end and
//   too_long set) from the error state, with busy high for one cycle.
//   output: each result is on out_data for one cycle with out_valid high;
//   the receiver cannot stall, so there is no backpressure path.
//   reset (rst_n low, synchronous) empties the store and the count and
//   drops any frame in progress; store contents are not cleared.
// ----------------------------------------------------------------------------
module crc8_packet_framer import cpf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  // command and status link between sequencer and datapath
  cpf_cmd_t cmd;
  cpf_sts_t sts;

  // sequencer: request intake, crc walk, frame emission
  cpf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .is_last (in_data.is_last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  // datapath: payload store, count, crc and registered result
  cpf_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/frame_check_pkg.sv =====
// ----------------------------------------------------------------------------
// frame_check_pkg: frame tracker for the crc8 packet framer bench
// mirrors the payload store and builds the expected frame for every closing
// request, then checks each strobed frame byte against the oldest one due
// ----------------------------------------------------------------------------
package frame_check_pkg;
  import cpf_pkg::*;

  class frame_tracker;
    localparam int HDR_LEN      = 4;
    localparam int REPORT_LIMIT = 10;

    logic [7:0] held_bytes [MAX_PAYLOAD_DEF];
    int         held_count;
    bit         dropped;
    out_item_t  frame_bytes_due [$];
    int         errors;

    function new();
      held_count = 0;
      dropped    = 1'b0;
      errors     = 0;
    endfunction

    // msb-first crc byte step in the framer's order: the poly test comes after the shift
    static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      repeat (8) begin
        acc = acc << 1;
        if (acc[7]) begin
          acc = acc ^ CRC_POLY;
        end
      end
      return acc;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%s", msg);
      end
    endfunction

    function int pending();
      return frame_bytes_due.size();
    endfunction

    function void note_request(in_item_t req);
      logic [7:0] hdr [HDR_LEN];
      logic [7:0] crc;
      int         total;
      out_item_t  want;
      if (req.has_byte) begin
        if (held_count < MAX_PAYLOAD_DEF) begin
          held_bytes[held_count] = req.payload_byte;
          held_count++;
        end else begin
          dropped = 1'b1;
        end
      end
      if (!req.is_last) begin
        return;
      end
      if (dropped) begin
        want.frame_byte = 8'h00;
        want.frame_end  = 1'b1;
        want.too_long   = 1'b1;
        frame_bytes_due.push_back(want);
      end else begin
        hdr[STEP_SYNC_A] = SYNC_A;
        hdr[STEP_SYNC_B] = SYNC_B;
        hdr[STEP_LEN]    = 8'(held_count);
        hdr[STEP_CRC]    = 8'h00;
        crc = 8'h00;
        for (int i = 0; i < HDR_LEN; i++) begin
          crc = crc8_step(crc, hdr[i]);
        end
        for (int i = 0; i < held_count; i++) begin
          crc = crc8_step(crc, held_bytes[i]);
        end
        hdr[STEP_CRC] = crc;
        total = HDR_LEN + held_count;
        for (int i = 0; i < total; i++) begin
          want.frame_byte = (i < HDR_LEN) ? hdr[i] : held_bytes[i - HDR_LEN];
          want.frame_end  = (i + 1 == total);
          want.too_long   = 1'b0;
          frame_bytes_due.push_back(want);
        end
      end
      held_count = 0;
      dropped    = 1'b0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (frame_bytes_due.size() == 0) begin
        flag($sformatf("unexpected result: byte=%02h end=%0b too_long=%0b",
                       got.frame_byte, got.frame_end, got.too_long));
        return;
      end
      want = frame_bytes_due.pop_front();
      if (got.frame_byte !== want.frame_byte || got.frame_end !== want.frame_end ||
          got.too_long !== want.too_long) begin
        flag($sformatf("result mismatch: expected byte=%02h end=%0b too_long=%0b, got byte=%02h end=%0b too_long=%0b",
                       want.frame_byte, want.frame_end, want.too_long,
                       got.frame_byte, got.frame_end, got.too_long));
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the crc8 packet framer
// drives payload requests and closing marks, predicts every frame byte
// (header, length, crc, payload) or the too-long flag, and checks each
// strobed result in order; sender gaps vary over three phases
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpf_pkg::*;
  import frame_check_pkg::*;

  localparam int MAX_BYTES = MAX_PAYLOAD_DEF;
  // longest frame's busy time, plus margin
  localparam int DRAIN_CYCLES = 2 * MAX_BYTES + 24;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  frame_tracker tracker;

  // percent chance of a gap ahead of each request
  int unsigned idle_pct;
  // requests that carry a byte or a last mark
  int unsigned counted;

  crc8_packet_framer #(.MAX_PAYLOAD(MAX_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // monitor: sample both channels at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (rst_n) begin
      // results from older frames leave before a new closing request adds its own
      if (out_valid) begin
        tracker.check_result(out_data);
      end
      if (start && !busy) begin
        tracker.note_request(in_data);
      end
    end
  end

  // one request: optional gap, then hold start until the framer takes it
  task automatic send_request(input in_item_t req);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      // junk on the data lines while start is low must be ignored
      in_data <= 10'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    if (req.has_byte || req.is_last) begin
      counted++;
    end
  endtask

  // n payload bytes, closed either on the last byte or by a bare last mark
  task automatic send_frame(input int n_bytes, input bit close_with_byte);
    in_item_t req;
    for (int i = 0; i < n_bytes; i++) begin
      req.payload_byte = 8'($urandom);
      req.has_byte     = 1'b1;
      req.is_last      = close_with_byte && (i == n_bytes - 1);
      send_request(req);
      // sprinkle requests that carry nothing
      if ($urandom_range(9) == 0) begin
        req.payload_byte = 8'($urandom);
        req.has_byte     = 1'b0;
        req.is_last      = 1'b0;
        send_request(req);
      end
    end
    if (!close_with_byte || n_bytes == 0) begin
      req.payload_byte = 8'($urandom);
      req.has_byte     = 1'b0;
      req.is_last      = 1'b1;
      send_request(req);
    end
  endtask

  // mostly well-formed frames of random size, some at capacity, some too long
  function automatic int pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) begin
      return $urandom_range(MAX_BYTES + 1, MAX_BYTES + 4);
    end
    if (r < 30) begin
      return MAX_BYTES;
    end
    if (r < 40) begin
      return 0;
    end
    return $urandom_range(1, MAX_BYTES - 1);
  endfunction

  task automatic run_phase(input int unsigned pct, input int unsigned quota);
    int unsigned stop_at;
    idle_pct = pct;
    stop_at  = counted + quota;
    while (counted < stop_at) begin
      send_frame(pick_length(), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    in_item_t req;
    tracker  = new();
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    idle_pct = 0;
    counted  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // request with neither byte nor last mark: nothing should happen
    send_request('{payload_byte: 8'hFF, has_byte: 1'b0, is_last: 1'b0});
    // empty payload: header only, length zero
    send_request('{payload_byte: 8'h5A, has_byte: 1'b0, is_last: 1'b1});
    // byte and last mark in one request
    send_request('{payload_byte: 8'hFF, has_byte: 1'b1, is_last: 1'b1});
    // full store, bytes 00..ff, last mark on the final byte
    for (int i = 0; i < MAX_BYTES; i++) begin
      req.payload_byte = 8'(i * 8'h11);
      req.has_byte     = 1'b1;
      req.is_last      = (i == MAX_BYTES - 1);
      send_request(req);
    end
    // single zero byte, then a bare last mark
    send_request('{payload_byte: 8'h00, has_byte: 1'b1, is_last: 1'b0});
    send_request('{payload_byte: 8'h00, has_byte: 1'b0, is_last: 1'b1});

    // random part: sender gaps heavy, heavier, then none
    run_phase(36, 75);
    run_phase(52, 75);
    run_phase(0, 75);

    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/cpf_pkg.sv
src/cpf_ram.sv
src/cpf_datapath.sv
src/cpf_ctrl.sv
src/crc8_packet_framer.sv
tb/frame_check_pkg.sv
tb/tb.sv
